/* design/sha512_pkg.sv */
// ----------------------------------------------------------------------------
// sha512_pkg
// Shared types and constants for the SHA-512 hash engine.
// ----------------------------------------------------------------------------
`default_nettype none
package sha512_pkg;

  localparam int unsigned NumRounds = 80;
  localparam int unsigned BlockWords = 16;

  localparam logic [7:0] PadByte = 8'h80;

  // Datapath command from the controller.
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_INIT  = 3'd1,  // load working vars from chaining value
    CMD_ROUND = 3'd2,  // one compression round
    CMD_FOLD  = 3'd3,  // add working vars into chaining value
    CMD_RESET = 3'd4   // chaining value back to IV
  } cmd_e;

  typedef struct packed {
    cmd_e       op;
    logic [6:0] rnd;
  } dp_ctrl_t;

  function automatic logic [63:0] iv_f(input logic [2:0] i);
    logic [63:0] r;
    case (i)
      3'd0: r = 64'h6a09e667f3bcc908;
      3'd1: r = 64'hbb67ae8584caa73b;
      3'd2: r = 64'h3c6ef372fe94f82b;
      3'd3: r = 64'ha54ff53a5f1d36f1;
      3'd4: r = 64'h510e527fade682d1;
      3'd5: r = 64'h9b05688c2b3e6c1f;
      3'd6: r = 64'h1f83d9abfb41bd6b;
      default: r = 64'h5be0cd19137e2179;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] k_f(input logic [6:0] t);
    logic [63:0] r;
    case (t)
      7'd0: r = 64'h428a2f98d728ae22; 7'd1: r = 64'h7137449123ef65cd;
      7'd2: r = 64'hb5c0fbcfec4d3b2f; 7'd3: r = 64'he9b5dba58189dbbc;
      7'd4: r = 64'h3956c25bf348b538; 7'd5: r = 64'h59f111f1b605d019;
      7'd6: r = 64'h923f82a4af194f9b; 7'd7: r = 64'hab1c5ed5da6d8118;
      7'd8: r = 64'hd807aa98a3030242; 7'd9: r = 64'h12835b0145706fbe;
      7'd10: r = 64'h243185be4ee4b28c; 7'd11: r = 64'h550c7dc3d5ffb4e2;
      7'd12: r = 64'h72be5d74f27b896f; 7'd13: r = 64'h80deb1fe3b1696b1;
      7'd14: r = 64'h9bdc06a725c71235; 7'd15: r = 64'hc19bf174cf692694;
      7'd16: r = 64'he49b69c19ef14ad2; 7'd17: r = 64'hefbe4786384f25e3;
      7'd18: r = 64'h0fc19dc68b8cd5b5; 7'd19: r = 64'h240ca1cc77ac9c65;
      7'd20: r = 64'h2de92c6f592b0275; 7'd21: r = 64'h4a7484aa6ea6e483;
      7'd22: r = 64'h5cb0a9dcbd41fbd4; 7'd23: r = 64'h76f988da831153b5;
      7'd24: r = 64'h983e5152ee66dfab; 7'd25: r = 64'ha831c66d2db43210;
      7'd26: r = 64'hb00327c898fb213f; 7'd27: r = 64'hbf597fc7beef0ee4;
      7'd28: r = 64'hc6e00bf33da88fc2; 7'd29: r = 64'hd5a79147930aa725;
      7'd30: r = 64'h06ca6351e003826f; 7'd31: r = 64'h142929670a0e6e70;
      7'd32: r = 64'h27b70a8546d22ffc; 7'd33: r = 64'h2e1b21385c26c926;
      7'd34: r = 64'h4d2c6dfc5ac42aed; 7'd35: r = 64'h53380d139d95b3df;
      7'd36: r = 64'h650a73548baf63de; 7'd37: r = 64'h766a0abb3c77b2a8;
      7'd38: r = 64'h81c2c92e47edaee6; 7'd39: r = 64'h92722c851482353b;
      7'd40: r = 64'ha2bfe8a14cf10364; 7'd41: r = 64'ha81a664bbc423001;
      7'd42: r = 64'hc24b8b70d0f89791; 7'd43: r = 64'hc76c51a30654be30;
      7'd44: r = 64'hd192e819d6ef5218; 7'd45: r = 64'hd69906245565a910;
      7'd46: r = 64'hf40e35855771202a; 7'd47: r = 64'h106aa07032bbd1b8;
      7'd48: r = 64'h19a4c116b8d2d0c8; 7'd49: r = 64'h1e376c085141ab53;
      7'd50: r = 64'h2748774cdf8eeb99; 7'd51: r = 64'h34b0bcb5e19b48a8;
      7'd52: r = 64'h391c0cb3c5c95a63; 7'd53: r = 64'h4ed8aa4ae3418acb;
      7'd54: r = 64'h5b9cca4f7763e373; 7'd55: r = 64'h682e6ff3d6b2b8a3;
      7'd56: r = 64'h748f82ee5defb2fc; 7'd57: r = 64'h78a5636f43172f60;
      7'd58: r = 64'h84c87814a1f0ab72; 7'd59: r = 64'h8cc702081a6439ec;
      7'd60: r = 64'h90befffa23631e28; 7'd61: r = 64'ha4506cebde82bde9;
      7'd62: r = 64'hbef9a3f7b2c67915; 7'd63: r = 64'hc67178f2e372532b;
      7'd64: r = 64'hca273eceea26619c; 7'd65: r = 64'hd186b8c721c0c207;
      7'd66: r = 64'heada7dd6cde0eb1e; 7'd67: r = 64'hf57d4f7fee6ed178;
      7'd68: r = 64'h06f067aa72176fba; 7'd69: r = 64'h0a637dc5a2c898a6;
      7'd70: r = 64'h113f9804bef90dae; 7'd71: r = 64'h1b710b35131c471b;
      7'd72: r = 64'h28db77f523047d84; 7'd73: r = 64'h32caab7b40c72493;
      7'd74: r = 64'h3c9ebe0a15c9bebc; 7'd75: r = 64'h431d67c49c100d4c;
      7'd76: r = 64'h4cc5d4becb3e42b6; 7'd77: r = 64'h597f299cfc657e2a;
      7'd78: r = 64'h5fcb6fab3ad6faec; default: r = 64'h6c44198c4a475817;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* design/sha512_hash_engine.sv */
// ----------------------------------------------------------------------------
// sha512_hash_engine
// SHA-512 engine: packs message bytes, pads, compresses, emits the digest.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                           tuser  tlast
//  s_axis    in   [63:0] message_word,[67:64] cnt  -      end_of_message
//  m_axis    out  [63:0] digest_word,[66:64] idx   -      last_word
//
//  Each beat is accepted in idle, then the byte packer moves its valid
//  bytes into the block one at a time. A full block goes through the
//  single round unit (load, 80 rounds, fold); the end beat adds a padding
//  step and one or two blocks, then the 8 digest words go out.
//  One beat at a time: s_axis_tready is high only when the engine is idle.
//  Digest beats hold until m_axis_tready; the chaining value is loaded with
//  the initial value in the first cycle after reset and after each digest.
// ----------------------------------------------------------------------------
`default_nettype none
module sha512_hash_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,   // [63:0] message_word, [67:64] bytes_valid
  input  wire logic        s_axis_tlast,   // end_of_message
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,   // [63:0] digest_word, [66:64] word_index
  output logic             m_axis_tlast    // last_word
);
  import sha512_pkg::*;

  dp_ctrl_t       ctrl;
  logic           blk_load;
  logic [1023:0]  blk;
  logic [2:0]     oidx;
  logic [63:0]    cv_word;
  logic           rst_seen_q;
  dp_ctrl_t       ctrl_mux;

  sha512_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .word_i(s_axis_tdata[63:0]), .cnt_i(s_axis_tdata[67:64]), .end_i(s_axis_tlast),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_ready_i(m_axis_tready), .out_valid_o(m_axis_tvalid), .out_idx_o(oidx),
    .ctrl_o(ctrl), .blk_load_o(blk_load), .blk_o(blk)
  );

  // chaining value has no reset; load IV in the first cycle after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rst_seen_q <= 1'b0;
    else rst_seen_q <= 1'b1;
  end
  always_comb begin
    ctrl_mux = ctrl;
    if (!rst_seen_q) ctrl_mux.op = CMD_RESET;
  end

  sha512_core u_core (
    .clk_i, .ctrl_i(ctrl_mux), .blk_load_i(blk_load), .blk_i(blk),
    .rd_idx_i(oidx), .cv_word_o(cv_word)
  );

  assign m_axis_tdata = {5'd0, oidx, cv_word};
  assign m_axis_tlast = oidx == 3'd7;
endmodule
`default_nettype wire

/* design/sha512_core.sv */
// ----------------------------------------------------------------------------
// sha512_core
// Compression datapath: 16-word schedule window, working vars, chaining value.
// ----------------------------------------------------------------------------
`default_nettype none
module sha512_core (
  input  wire logic                  clk_i,
  input  wire sha512_pkg::dp_ctrl_t  ctrl_i,
  input  wire logic                  blk_load_i,  // load window from block
  input  wire logic [1023:0]         blk_i,       // word 0 in top bits
  input  wire logic [2:0]            rd_idx_i,
  output logic [63:0]                cv_word_o
);
  import sha512_pkg::*;

  logic [63:0] w_q [BlockWords];
  logic [63:0] v_q [8];
  logic [63:0] cv_q [8];

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

  logic [63:0] s0, s1, wn, e, a, t1, t2;
  always_comb begin
    s0 = rotr(w_q[1], 1) ^ rotr(w_q[1], 8) ^ (w_q[1] >> 7);
    s1 = rotr(w_q[14], 19) ^ rotr(w_q[14], 61) ^ (w_q[14] >> 6);
    wn = s1 + w_q[9] + s0 + w_q[0];
    a = v_q[0];
    e = v_q[4];
    t1 = v_q[7] + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41)) + ((e & v_q[5]) ^ (~e & v_q[6]))
       + k_f(ctrl_i.rnd) + w_q[0];
    t2 = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39))
       + ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  assign cv_word_o = cv_q[rd_idx_i];

  always_ff @(posedge clk_i) begin
    if (blk_load_i) begin
      for (int i = 0; i < BlockWords; i++) w_q[i] <= blk_i[1023 - 64*i -: 64];
    end else if (ctrl_i.op == CMD_ROUND) begin
      for (int i = 0; i < BlockWords - 1; i++) w_q[i] <= w_q[i+1];
      w_q[BlockWords-1] <= wn;
    end
    case (ctrl_i.op)
      CMD_RESET: for (int i = 0; i < 8; i++) cv_q[i] <= iv_f(3'(i));
      CMD_INIT:  for (int i = 0; i < 8; i++) v_q[i] <= cv_q[i];
      CMD_ROUND: begin
        v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
        v_q[4] <= v_q[3] + t1;
        v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
        v_q[0] <= t1 + t2;
      end
      CMD_FOLD:  for (int i = 0; i < 8; i++) cv_q[i] <= cv_q[i] + v_q[i];
      default: ;
    endcase
  end
endmodule
`default_nettype wire

/* design/sha512_ctrl.sv */
// ----------------------------------------------------------------------------
// sha512_ctrl
// Sequencer: byte packing, padding, round count, digest output.
// ----------------------------------------------------------------------------
`default_nettype none
module sha512_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [63:0]          word_i,
  input  wire logic [3:0]           cnt_i,
  input  wire logic                 end_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output logic [2:0]                out_idx_o,
  output sha512_pkg::dp_ctrl_t      ctrl_o,
  output logic                      blk_load_o,
  output logic [1023:0]             blk_o
);
  import sha512_pkg::*;

  // padding phase
  localparam logic [1:0] PadNone = 2'd0;  // message data
  localparam logic [1:0] PadMore = 2'd1;  // pad block, length needs another block
  localparam logic [1:0] PadLast = 2'd2;  // final block

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PACK  = 6'b000010,  // one byte per cycle into the block
    ST_INIT  = 6'b000100,
    ST_ROUND = 6'b001000,
    ST_FOLD  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

  state_e        state_q, state_d;
  logic [1023:0] blk_q;
  logic [6:0]    pos_q;
  logic [127:0]  bits_q;
  logic [63:0]   word_q;
  logic [3:0]    left_q;
  logic          end_q;
  logic [1:0]    pad_q;
  logic [6:0]    rnd_q;
  logic [2:0]    oidx_q;

  logic [127:0] bits_pad;
  assign bits_pad = bits_q + {118'd0, pos_q, 3'd0};

  logic [1023:0] pad_blk;
  always_comb begin
    pad_blk = blk_q;
    for (int i = 0; i < 128; i++) begin
      if (7'(i) == pos_q) pad_blk[1023 - 8*i -: 8] = PadByte;
      else if (7'(i) > pos_q) pad_blk[1023 - 8*i -: 8] = 8'h00;
    end
    // length fits behind the pad byte
    if (pos_q < 7'd112) pad_blk[127:0] = bits_pad;
  end

  assign in_ready_o = state_q == ST_IDLE;
  assign out_valid_o = state_q == ST_OUT;
  assign out_idx_o = oidx_q;
  assign blk_o = blk_q;

  always_comb begin
    state_d = state_q;
    ctrl_o.op = CMD_NONE;
    ctrl_o.rnd = rnd_q;
    blk_load_o = 1'b0;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_PACK;
      ST_PACK: begin
        if (left_q == 4'd0) begin
          if (!end_q) state_d = ST_IDLE;
          else state_d = ST_INIT;  // padding prepared in clocked block
        end else if (pos_q == 7'd127) begin
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        ctrl_o.op = CMD_INIT;
        blk_load_o = 1'b1;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        ctrl_o.op = CMD_ROUND;
        if (rnd_q == 7'(NumRounds - 1)) state_d = ST_FOLD;
      end
      ST_FOLD: begin
        ctrl_o.op = CMD_FOLD;
        if (pad_q == PadLast) state_d = ST_OUT;
        else if (pad_q == PadMore) state_d = ST_INIT;
        else if (left_q == 4'd0 && !end_q) state_d = ST_IDLE;
        else state_d = ST_PACK;
      end
      ST_OUT: begin
        if (out_ready_i && oidx_q == 3'd7) begin
          state_d = ST_IDLE;
          ctrl_o.op = CMD_RESET;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q <= '0;
      bits_q <= '0;
      left_q <= '0;
      end_q <= 1'b0;
      pad_q <= PadNone;
      rnd_q <= '0;
      oidx_q <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: if (in_valid_i) begin
          left_q <= (cnt_i > 4'd8) ? 4'd8 : cnt_i;
          end_q <= end_i;
          pad_q <= PadNone;
        end
        ST_PACK: begin
          if (left_q != 4'd0) begin
            pos_q <= pos_q + 7'd1;
            left_q <= left_q - 4'd1;
            if (pos_q == 7'd127) bits_q <= bits_q + 128'd1024;
          end else if (end_q) begin
            bits_q <= bits_pad;
            pad_q <= (pos_q >= 7'd112) ? PadMore : PadLast;
          end
        end
        ST_INIT: rnd_q <= '0;
        ST_ROUND: rnd_q <= rnd_q + 7'd1;
        ST_FOLD: if (pad_q == PadMore) pad_q <= PadLast;
        ST_OUT: if (out_ready_i) begin
          oidx_q <= oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            pos_q <= '0;
            bits_q <= '0;
            end_q <= 1'b0;
            pad_q <= PadNone;
          end
        end
        default: ;
      endcase
    end
  end

  // block buffer payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) word_q <= word_i;
    if (state_q == ST_PACK) begin
      if (left_q != 4'd0) begin
        blk_q[1023 - 8*pos_q -: 8] <= word_q[63:56];
        word_q <= {word_q[55:0], 8'h00};
      end else if (end_q) begin
        blk_q <= pad_blk;
      end
    end
    // after first of two pad blocks: zeros plus length
    if (state_q == ST_FOLD && pad_q == PadMore) blk_q <= {896'd0, bits_q};
  end
endmodule
`default_nettype wire
